FILE: src/dsfr_pkg.sv
// Shared types, symbol codes and CRC-16 byte update for the DLE/STX frame receiver.
`default_nettype none
package dsfr_pkg;

  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;
  localparam logic [7:0] SYM_ENQ = 8'h05;
  localparam logic [7:0] SYM_ACK = 8'h06;
  localparam logic [7:0] SYM_NAK = 8'h15;

  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2
  } kind_t;

  typedef enum logic [5:0] {
    PH_HUNT      = 6'b000001,
    PH_HUNT_DLE  = 6'b000010,
    PH_FRAME     = 6'b000100,
    PH_FRAME_DLE = 6'b001000,
    PH_CRC_LO    = 6'b010000,
    PH_CRC_HI    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
  } result_t;

  // reflected CRC-16, one byte
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {crc[15:8], crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: src/dsfr_in_stage.sv
// Input register stage holding one received byte.
`default_nettype none
module dsfr_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       take,
  output logic            held_valid,
  output logic [7:0]      held_byte
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule
`default_nettype wire

FILE: src/dsfr_decoder.sv
// Frame phase tracking, unstuffing and CRC check for one byte per cycle while take is high.
`default_nettype none
module dsfr_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] byte_in,
  output dsfr_pkg::result_t res
);

  dsfr_pkg::phase_t phase, phase_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic [7:0]  crc_low_received;
  logic [15:0] crc_of_byte;
  logic [15:0] crc_of_dle;
  logic [15:0] crc_of_etx;
  logic        is_term;

  assign crc_of_byte = dsfr_pkg::crc_update(crc_accum, byte_in);
  assign crc_of_dle  = dsfr_pkg::crc_update(crc_accum, dsfr_pkg::SYM_DLE);
  assign crc_of_etx  = dsfr_pkg::crc_update(crc_accum, dsfr_pkg::SYM_ETX);
  assign is_term = (byte_in == dsfr_pkg::SYM_ENQ) || (byte_in == dsfr_pkg::SYM_ACK) ||
                   (byte_in == dsfr_pkg::SYM_NAK);

  always_comb begin
    phase_next     = dsfr_pkg::PH_HUNT;
    crc_accum_next = crc_accum;
    res.valid      = 1'b0;
    res.kind       = dsfr_pkg::KIND_DATA;
    res.data       = 8'h00;
    unique case (phase)
      dsfr_pkg::PH_HUNT_DLE: begin
        if (byte_in == dsfr_pkg::SYM_STX) begin
          phase_next     = dsfr_pkg::PH_FRAME;
          crc_accum_next = 16'h0000;
        end else if (is_term || byte_in == dsfr_pkg::SYM_ETX) begin
          res.valid = 1'b1;
          res.kind  = dsfr_pkg::KIND_NAK;
        end
      end
      dsfr_pkg::PH_FRAME: begin
        if (byte_in == dsfr_pkg::SYM_DLE) begin
          phase_next = dsfr_pkg::PH_FRAME_DLE;
        end else begin
          phase_next     = dsfr_pkg::PH_FRAME;
          crc_accum_next = crc_of_byte;
          res.valid      = 1'b1;
          res.data       = byte_in;
        end
      end
      dsfr_pkg::PH_FRAME_DLE: begin
        if (byte_in == dsfr_pkg::SYM_ETX) begin
          phase_next     = dsfr_pkg::PH_CRC_LO;
          crc_accum_next = crc_of_etx;
        end else if (is_term || byte_in == dsfr_pkg::SYM_STX) begin
          res.valid = 1'b1;
          res.kind  = dsfr_pkg::KIND_NAK;
        end else begin
          // DLE DLE or DLE + other byte: one DLE, second byte dropped
          phase_next     = dsfr_pkg::PH_FRAME;
          crc_accum_next = crc_of_dle;
          res.valid      = 1'b1;
          res.data       = dsfr_pkg::SYM_DLE;
        end
      end
      dsfr_pkg::PH_CRC_LO: begin
        phase_next = dsfr_pkg::PH_CRC_HI;
      end
      dsfr_pkg::PH_CRC_HI: begin
        res.valid = 1'b1;
        res.kind  = ({byte_in, crc_low_received} == crc_accum) ? dsfr_pkg::KIND_ACK
                                                                : dsfr_pkg::KIND_NAK;
      end
      default: begin
        phase_next = (byte_in == dsfr_pkg::SYM_DLE) ? dsfr_pkg::PH_HUNT_DLE
                                                     : dsfr_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= dsfr_pkg::PH_HUNT;
      crc_accum <= 16'h0000;
    end else if (take) begin
      phase     <= phase_next;
      crc_accum <= crc_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && phase == dsfr_pkg::PH_CRC_LO) begin
      crc_low_received <= byte_in;
    end
  end

endmodule
`default_nettype wire

FILE: src/dle_stx_frame_receiver_crc16.sv
// An accepted byte is held in the input reg, then its result goes to the result reg.
// Throughput: one byte per cycle unless out_ready back-pressure stalls; the byte-wide CRC-16
// update and phase decode fit in the single stage between the input and result registers.
// Reset (synchronous, active high): hunting phase, CRC cleared, both stages empty.
`default_nettype none
module dle_stx_frame_receiver_crc16 (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_kind,
  output logic [7:0]      payload_byte
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              take;
  dsfr_pkg::result_t res;

  assign take = held_valid && (!out_valid || out_ready);

  dsfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  dsfr_decoder u_dec (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .byte_in (held_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_kind     <= res.kind;
      payload_byte <= res.data;
    end
  end

endmodule
`default_nettype wire

FILE: test/dle_stx_frame_receiver_crc16_test.sv
// Testbench for the DLE/STX frame receiver: directed table, random frames, result scoreboard.
module dle_stx_frame_receiver_crc16_test;

  localparam int FRAME_ITEMS = 550;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_CAP  = 40;
  localparam int PLAN_LEN    = 28;

  typedef enum logic [1:0] {
    ROW_RAW,
    ROW_CRC_LO,
    ROW_CRC_HI,
    ROW_CRC_BAD
  } row_op_t;

  typedef struct packed {
    dsfr_pkg::kind_t kind;
    logic [7:0]      data;
  } reply_t;

  typedef struct packed {
    row_op_t         op;
    logic [7:0]      b;
    logic            typed;
    logic            has_reply;
    dsfr_pkg::kind_t kind;
    logic [7:0]      data;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] payload_byte;

  // line state as the receiver should see it
  dsfr_pkg::phase_t link_phase = dsfr_pkg::PH_HUNT;
  logic [15:0]      frame_crc = 16'h0000;
  logic [7:0]       crc_lo_seen = 8'h00;

  reply_t replies_due[$];
  int     fault_count = 0;
  int     frame_items = 0;
  int     cycles = 0;
  int     sink_hold = 0;
  bit     src_calm = 1'b0;
  bit     sink_calm = 1'b0;

  // typed rows carry their expected result, the rest go through the predictor
  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_RAW,     dsfr_pkg::SYM_DLE, 1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_ENQ, 1'b1, 1'b1, dsfr_pkg::KIND_NAK,  8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_DLE, 1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     8'h41,             1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_DLE, 1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_STX, 1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     8'h00,             1'b1, 1'b1, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     8'hFF,             1'b1, 1'b1, dsfr_pkg::KIND_DATA, 8'hFF},
    '{ROW_RAW,     dsfr_pkg::SYM_DLE, 1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_DLE, 1'b1, 1'b1, dsfr_pkg::KIND_DATA, dsfr_pkg::SYM_DLE},
    '{ROW_RAW,     dsfr_pkg::SYM_DLE, 1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     8'h7E,             1'b1, 1'b1, dsfr_pkg::KIND_DATA, dsfr_pkg::SYM_DLE},
    '{ROW_RAW,     dsfr_pkg::SYM_DLE, 1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_ETX, 1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_CRC_LO,  8'h00,             1'b0, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_CRC_HI,  8'h00,             1'b1, 1'b1, dsfr_pkg::KIND_ACK,  8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_DLE, 1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_STX, 1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_DLE, 1'b0, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_ETX, 1'b0, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_CRC_LO,  8'h00,             1'b0, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_CRC_BAD, 8'h00,             1'b1, 1'b1, dsfr_pkg::KIND_NAK,  8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_DLE, 1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_STX, 1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_DLE, 1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_STX, 1'b1, 1'b1, dsfr_pkg::KIND_NAK,  8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_DLE, 1'b1, 1'b0, dsfr_pkg::KIND_DATA, 8'h00},
    '{ROW_RAW,     dsfr_pkg::SYM_ETX, 1'b1, 1'b1, dsfr_pkg::KIND_NAK,  8'h00}
  };

  dle_stx_frame_receiver_crc16 DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .payload_byte(payload_byte)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ dsfr_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // advances the line state by one byte; returns 1 when a result is due
  function automatic logic predict_rx(input logic [7:0] b, output reply_t r);
    logic fired;
    fired = 1'b0;
    r = reply_t'{dsfr_pkg::KIND_DATA, 8'h00};
    case (link_phase)
      dsfr_pkg::PH_HUNT_DLE: begin
        link_phase = dsfr_pkg::PH_HUNT;
        if (b == dsfr_pkg::SYM_STX) begin
          link_phase = dsfr_pkg::PH_FRAME;
          frame_crc = 16'h0000;
        end else if (b == dsfr_pkg::SYM_ENQ || b == dsfr_pkg::SYM_ETX ||
                     b == dsfr_pkg::SYM_ACK || b == dsfr_pkg::SYM_NAK) begin
          r.kind = dsfr_pkg::KIND_NAK;
          fired = 1'b1;
        end
      end
      dsfr_pkg::PH_FRAME: begin
        if (b == dsfr_pkg::SYM_DLE) begin
          link_phase = dsfr_pkg::PH_FRAME_DLE;
        end else begin
          frame_crc = crc16_step(frame_crc, b);
          r.data = b;
          fired = 1'b1;
        end
      end
      dsfr_pkg::PH_FRAME_DLE: begin
        if (b == dsfr_pkg::SYM_ETX) begin
          frame_crc = crc16_step(frame_crc, dsfr_pkg::SYM_ETX);
          link_phase = dsfr_pkg::PH_CRC_LO;
        end else if (b == dsfr_pkg::SYM_STX || b == dsfr_pkg::SYM_ENQ ||
                     b == dsfr_pkg::SYM_ACK || b == dsfr_pkg::SYM_NAK) begin
          link_phase = dsfr_pkg::PH_HUNT;
          r.kind = dsfr_pkg::KIND_NAK;
          fired = 1'b1;
        end else begin
          link_phase = dsfr_pkg::PH_FRAME;
          frame_crc = crc16_step(frame_crc, dsfr_pkg::SYM_DLE);
          r.data = dsfr_pkg::SYM_DLE;
          fired = 1'b1;
        end
      end
      dsfr_pkg::PH_CRC_LO: begin
        crc_lo_seen = b;
        link_phase = dsfr_pkg::PH_CRC_HI;
      end
      dsfr_pkg::PH_CRC_HI: begin
        link_phase = dsfr_pkg::PH_HUNT;
        r.kind = ({b, crc_lo_seen} == frame_crc) ? dsfr_pkg::KIND_ACK : dsfr_pkg::KIND_NAK;
        fired = 1'b1;
      end
      default: begin
        link_phase = (b == dsfr_pkg::SYM_DLE) ? dsfr_pkg::PH_HUNT_DLE : dsfr_pkg::PH_HUNT;
      end
    endcase
    return fired;
  endfunction

  function automatic int pick_gap(input bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0, 1: return dsfr_pkg::SYM_DLE;
      2: return dsfr_pkg::SYM_STX;
      3: return dsfr_pkg::SYM_ETX;
      4: return dsfr_pkg::SYM_ENQ;
      5: return dsfr_pkg::SYM_ACK;
      6: return dsfr_pkg::SYM_NAK;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] abort_byte();
    case ($urandom_range(0, 3))
      0: return dsfr_pkg::SYM_STX;
      1: return dsfr_pkg::SYM_ENQ;
      2: return dsfr_pkg::SYM_ACK;
      default: return dsfr_pkg::SYM_NAK;
    endcase
  endfunction

  task automatic flag_fault(input string msg);
    if (fault_count < REPORT_CAP) $display("mismatch @%0d: %s", cycles, msg);
    fault_count++;
  endtask

  // returns at the edge where the item is taken
  task automatic push_line_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
  endtask

  task automatic feed(input logic [7:0] b);
    reply_t r;
    push_line_byte(b);
    frame_items++;
    if (predict_rx(b, r)) begin
      replies_due.push_back(r);
    end
  endtask

  task automatic check_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      flag_fault($sformatf("unexpected result kind %0d byte %02h", out_kind, payload_byte));
    end else begin
      want = replies_due.pop_front();
      if (out_kind !== want.kind)
        flag_fault($sformatf("kind %0d, want %0d", out_kind, want.kind));
      if (payload_byte !== want.data)
        flag_fault($sformatf("byte %02h, want %02h", payload_byte, want.data));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_reply();
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        sink_hold <= sink_hold - 1;
      end else begin
        out_ready <= 1'b1;
        sink_hold <= pick_gap(sink_calm);
      end
      if ($urandom_range(0, 63) == 0) sink_calm <= !sink_calm;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    reply_t      r;
    logic        fired;
    logic [7:0]  nb;
    logic [15:0] spoil;
    int          body;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      case (plan[i].op)
        ROW_CRC_LO: nb = frame_crc[7:0];
        ROW_CRC_HI: nb = frame_crc[15:8];
        ROW_CRC_BAD: nb = frame_crc[15:8] ^ 8'h01;
        default: nb = plan[i].b;
      endcase
      push_line_byte(nb);
      frame_items++;
      fired = predict_rx(nb, r);
      if (plan[i].typed) begin
        if (plan[i].has_reply) replies_due.push_back(reply_t'{plan[i].kind, plan[i].data});
      end else if (fired) begin
        replies_due.push_back(r);
      end
    end

    while (frame_items < FRAME_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) feed(noise_byte());
      end else begin
        feed(dsfr_pkg::SYM_DLE);
        feed(dsfr_pkg::SYM_STX);
        body = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        for (int i = 0; i < body; i++) begin
          if ($urandom_range(0, 5) == 0) begin
            feed(dsfr_pkg::SYM_DLE);
            feed(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : dsfr_pkg::SYM_DLE);
          end else begin
            feed(8'($urandom_range(0, 255)));
          end
        end
        spoil = 16'h0000;
        case ($urandom_range(0, 9))
          0: begin
            feed(dsfr_pkg::SYM_DLE);
            feed(abort_byte());
          end
          1: spoil = 16'(1) << $urandom_range(0, 15);
          2: spoil = 16'($urandom_range(1, 65535));
          default: spoil = 16'h0000;
        endcase
        // close out whatever the frame has turned into
        while (link_phase != dsfr_pkg::PH_HUNT) begin
          case (link_phase)
            dsfr_pkg::PH_FRAME: nb = dsfr_pkg::SYM_DLE;
            dsfr_pkg::PH_FRAME_DLE: nb = dsfr_pkg::SYM_ETX;
            dsfr_pkg::PH_CRC_LO: nb = frame_crc[7:0] ^ spoil[7:0];
            dsfr_pkg::PH_CRC_HI: nb = frame_crc[15:8] ^ spoil[15:8];
            default: nb = 8'h00;
          endcase
          feed(nb);
        end
      end
    end

    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
